@@ src/bsp_point_region_locate_top_macros.svh @@
// Assertion helpers for the checks inside the locate block.
`ifndef BSP_POINT_REGION_LOCATE_TOP_MACROS_SVH
`define BSP_POINT_REGION_LOCATE_TOP_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define BSPRL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the same cycle.
`define BSPRL_ASSERT_IMPL(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

`endif

@@ src/bsprl_pkg.sv @@
`default_nettype none

package bsprl_pkg;

   // Node store depth, walk hop limit and fraction bits of the coordinates.
   localparam int MAX_NODES       = 1024;
   localparam int MAX_HOPS        = 1024;
   localparam int COORD_FRAC_BITS = 16;

   localparam int NODE_ADDR_W = $clog2(MAX_NODES);
   localparam int HOP_W       = $clog2(MAX_HOPS + 1);
   localparam int COORD_W     = 32;
   localparam int CHILD_W     = 11;
   localparam int SIZE_W      = 11;
   localparam int INDEX_W     = 10;
   localparam int STATUS_W    = 2;
   // Three full products plus the aligned offset never exceed this width.
   localparam int ACC_W       = 2 * COORD_W + 2;

   // Walk status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HOP_LIMIT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CHILD_OVER = 2'd2;

   // Request kinds carried on tuser.
   localparam logic FUNC_WRITE_NODE = 1'b0;
   localparam logic FUNC_LOCATE     = 1'b1;

   // Word index of the tree size register.
   localparam logic CSR_TREE_SIZE = 1'b0;

   typedef struct packed {
      logic signed [COORD_W-1:0] normal_x;
      logic signed [COORD_W-1:0] normal_y;
      logic signed [COORD_W-1:0] normal_z;
      logic signed [COORD_W-1:0] plane_offset;
      logic signed [CHILD_W-1:0] front_child;
      logic signed [CHILD_W-1:0] back_child;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic done;
      logic front;
   } plane_status_type;

   typedef enum logic [2:0] {
      PS_IDLE,
      PS_Y,
      PS_Z,
      PS_SUM,
      PS_DONE
   } plane_step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_TEST,
      ST_DONE
   } walk_state_type;

endpackage

`default_nettype wire

@@ src/bsprl_ram.sv @@
`default_nettype none

module bsprl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/bsprl_plane.sv @@
`default_nettype none

// Plane side test: dot(point, normal) + offset > 0, exact, one multiplier
// shared over the three components.
module bsprl_plane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire bsprl_pkg::node_type         node,
   input  wire bsprl_pkg::point_type        point,
   output bsprl_pkg::plane_status_type      status
);

   bsprl_pkg::plane_step_type step_ff, step_in;
   logic signed [2*bsprl_pkg::COORD_W-1:0] prod_ff, prod_in;
   logic signed [bsprl_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic signed [bsprl_pkg::COORD_W-1:0]   mul_a, mul_b;
   logic signed [2*bsprl_pkg::COORD_W-1:0] mul_out;
   logic signed [bsprl_pkg::ACC_W-1:0]     acc_sum;
   logic signed [bsprl_pkg::ACC_W-1:0]     off_ext;

   always_comb begin
      case (step_ff)
         bsprl_pkg::PS_IDLE: begin
            mul_a = point.x;
            mul_b = node.normal_x;
         end
         bsprl_pkg::PS_Y: begin
            mul_a = point.y;
            mul_b = node.normal_y;
         end
         default: begin
            mul_a = point.z;
            mul_b = node.normal_z;
         end
      endcase
   end

   assign mul_out = mul_a * mul_b;
   assign acc_sum = acc_ff + bsprl_pkg::ACC_W'(prod_ff);
   assign off_ext = bsprl_pkg::ACC_W'(node.plane_offset) <<< bsprl_pkg::COORD_FRAC_BITS;

   always_comb begin
      step_in = step_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      case (step_ff)
         bsprl_pkg::PS_IDLE: begin
            if (start) begin
               prod_in = mul_out;
               acc_in  = off_ext;
               step_in = bsprl_pkg::PS_Y;
            end
         end
         bsprl_pkg::PS_Y: begin
            acc_in  = acc_sum;
            prod_in = mul_out;
            step_in = bsprl_pkg::PS_Z;
         end
         bsprl_pkg::PS_Z: begin
            acc_in  = acc_sum;
            prod_in = mul_out;
            step_in = bsprl_pkg::PS_SUM;
         end
         bsprl_pkg::PS_SUM: begin
            acc_in  = acc_sum;
            step_in = bsprl_pkg::PS_DONE;
         end
         default: begin
            step_in = bsprl_pkg::PS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= bsprl_pkg::PS_IDLE;
      end else begin
         step_ff <= step_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign status.done  = (step_ff == bsprl_pkg::PS_DONE);
   assign status.front = !acc_ff[bsprl_pkg::ACC_W-1] && (acc_ff != '0);

endmodule

`default_nettype wire

@@ src/bsp_point_region_locate_top.sv @@
`default_nettype none

// Binary space partition point locator. A request whose tuser is 0 writes one
// tree node (plane normal, offset, front and back child codes) into the node
// memory in the cycle it is accepted; a request whose tuser is 1 walks the tree
// from node 0 and returns one response with the leaf code and a walk status
// (0 ok, 1 hop limit reached, 2 child at or beyond the tree size). For each
// node visited a query reads the node memory, then runs the plane test unit,
// whose single 32x32 multiplier forms the three products of the dot product
// one after another and sums them exactly with the shifted offset. A query on
// an empty tree answers without reading the node memory. The block takes one
// request at a time; a finished response sits in an output register so the
// next request can be accepted while it waits. The tree size register lies at
// byte address 0 of the configuration port and should only be written while
// the block is idle.
module bsp_point_region_locate_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata from bit 0 up: node_index[9:0], normal_x[31:0], normal_y[31:0],
   // normal_z[31:0], plane_offset[31:0], front_child[10:0], back_child[10:0],
   // point_x[31:0], point_y[31:0], point_z[31:0].
   input  wire logic [255:0] req_tdata,
   // tuser: func (0 write node, 1 locate point).
   input  wire logic [0:0]   req_tuser,
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata from bit 0 up: region_code[10:0], walk_status[1:0], zero fill.
   output logic [15:0]       rsp_tdata,
   // Configuration port.
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

`include "bsp_point_region_locate_top_macros.svh"

   // Request field unpacking.
   logic                                   req_func;
   logic [bsprl_pkg::INDEX_W-1:0]          req_node_index;
   bsprl_pkg::node_type                    req_node;
   bsprl_pkg::point_type                   req_point;
   logic                                   req_fire;

   assign req_func              = req_tuser[0];
   assign req_node_index        = req_tdata[9:0];
   assign req_node.normal_x     = req_tdata[41:10];
   assign req_node.normal_y     = req_tdata[73:42];
   assign req_node.normal_z     = req_tdata[105:74];
   assign req_node.plane_offset = req_tdata[137:106];
   assign req_node.front_child  = req_tdata[148:138];
   assign req_node.back_child   = req_tdata[159:149];
   assign req_point.x           = req_tdata[191:160];
   assign req_point.y           = req_tdata[223:192];
   assign req_point.z           = req_tdata[255:224];

   assign req_fire = req_tvalid && req_tready;

   // Configuration register. The word index is the byte address over four.
   logic [bsprl_pkg::SIZE_W-1:0] tree_size_ff;
   logic                         csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_size_ff <= '0;
      end else if (csr_write && (csr_paddr[2] == bsprl_pkg::CSR_TREE_SIZE)) begin
         tree_size_ff <= csr_pwdata[bsprl_pkg::SIZE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == bsprl_pkg::CSR_TREE_SIZE) ? 32'(tree_size_ff) : '0;

   // Node memory: one wide entry per node, written by node requests and read
   // once per hop of a walk. Requests are not accepted during a walk, so a
   // write never meets a read in flight.
   logic                                ram_we;
   logic [bsprl_pkg::NODE_ADDR_W-1:0]   ram_waddr;
   logic                                ram_re;
   logic [bsprl_pkg::NODE_ADDR_W-1:0]   ram_raddr;
   logic [bsprl_pkg::NODE_W-1:0]        ram_rdata;
   bsprl_pkg::node_type                 cur_node;
   logic [31:0]                         write_index_ext;

   assign write_index_ext = 32'(req_node_index);
   assign ram_we    = req_fire && (req_func == bsprl_pkg::FUNC_WRITE_NODE) &&
                      (write_index_ext < 32'(bsprl_pkg::MAX_NODES));
   assign ram_waddr = write_index_ext[bsprl_pkg::NODE_ADDR_W-1:0];
   assign cur_node  = bsprl_pkg::node_type'(ram_rdata);

   bsprl_ram #(
      .WIDTH (bsprl_pkg::NODE_W),
      .DEPTH (bsprl_pkg::MAX_NODES)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_node),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Query point, held for the whole walk.
   bsprl_pkg::point_type point_ff;

   always_ff @(posedge clock) begin
      if (req_fire && (req_func == bsprl_pkg::FUNC_LOCATE)) begin
         point_ff <= req_point;
      end
   end

   // Plane test of the current node.
   logic                         plane_start;
   bsprl_pkg::plane_status_type  plane_status;

   bsprl_plane u_plane (
      .clock  (clock),
      .reset  (reset),
      .start  (plane_start),
      .node   (cur_node),
      .point  (point_ff),
      .status (plane_status)
   );

   // Walk control.
   bsprl_pkg::walk_state_type            state_ff, state_in;
   logic [bsprl_pkg::HOP_W-1:0]          hops_ff, hops_in;
   logic signed [bsprl_pkg::CHILD_W-1:0] res_code_ff, res_code_in;
   logic [bsprl_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [bsprl_pkg::CHILD_W-1:0] rsp_code_ff, rsp_code_in;
   logic [bsprl_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [bsprl_pkg::CHILD_W-1:0] child;
   logic [31:0]                          child_ext;
   logic                                 child_is_leaf;
   logic                                 child_over;
   logic                                 rsp_free;

   assign child         = plane_status.front ? cur_node.front_child : cur_node.back_child;
   assign child_ext     = 32'(unsigned'(child));
   assign child_is_leaf = child[bsprl_pkg::CHILD_W-1] || (child == '0);
   // A size above the store depth counts as the store depth.
   assign child_over    = (child_ext >= 32'(tree_size_ff)) ||
                          (child_ext >= 32'(bsprl_pkg::MAX_NODES));
   assign rsp_free      = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == bsprl_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      hops_in       = hops_ff;
      res_code_in   = res_code_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_code_in   = rsp_code_ff;
      rsp_status_in = rsp_status_ff;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      plane_start   = 1'b0;
      case (state_ff)
         bsprl_pkg::ST_IDLE: begin
            if (req_fire && (req_func == bsprl_pkg::FUNC_LOCATE)) begin
               res_code_in   = '0;
               res_status_in = bsprl_pkg::STATUS_OK;
               if (tree_size_ff == '0) begin
                  state_in = bsprl_pkg::ST_DONE;
               end else begin
                  ram_re   = 1'b1;
                  hops_in  = bsprl_pkg::HOP_W'(1);
                  state_in = bsprl_pkg::ST_FETCH;
               end
            end
         end
         bsprl_pkg::ST_FETCH: begin
            plane_start = 1'b1;
            state_in    = bsprl_pkg::ST_TEST;
         end
         bsprl_pkg::ST_TEST: begin
            if (plane_status.done) begin
               if (child_is_leaf) begin
                  res_code_in = child;
                  state_in    = bsprl_pkg::ST_DONE;
               end else if (child_over) begin
                  res_status_in = bsprl_pkg::STATUS_CHILD_OVER;
                  state_in      = bsprl_pkg::ST_DONE;
               end else if (hops_ff >= bsprl_pkg::HOP_W'(bsprl_pkg::MAX_HOPS)) begin
                  res_status_in = bsprl_pkg::STATUS_HOP_LIMIT;
                  state_in      = bsprl_pkg::ST_DONE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = child_ext[bsprl_pkg::NODE_ADDR_W-1:0];
                  hops_in   = hops_ff + bsprl_pkg::HOP_W'(1);
                  state_in  = bsprl_pkg::ST_FETCH;
               end
            end
         end
         bsprl_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = res_code_ff;
               rsp_status_in = res_status_ff;
               state_in      = bsprl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsprl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsprl_pkg::ST_IDLE;
         hops_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hops_ff      <= hops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_code_ff   <= res_code_in;
      res_status_ff <= res_status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_status_ff, rsp_code_ff};

   // Checks on the walk control.
   `BSPRL_ASSERT_IMPL(a_plane_done_in_test, plane_status.done, state_ff == bsprl_pkg::ST_TEST, "plane result outside node test")
   `BSPRL_ASSERT(a_hops_bounded, hops_ff <= bsprl_pkg::HOP_W'(bsprl_pkg::MAX_HOPS), "hop count beyond limit")
   `BSPRL_ASSERT_IMPL(a_error_code_zero, rsp_valid_ff && (rsp_status_ff != bsprl_pkg::STATUS_OK), rsp_code_ff == '0, "error response with leaf code")
   `BSPRL_ASSERT_IMPL(a_read_then_fetch, $past(ram_re) && !$past(reset), state_ff == bsprl_pkg::ST_FETCH, "node read not followed by fetch")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;
   import bsprl_pkg::*;

   // Q16.16 coordinate and child code types at the widths of the request fields.
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [CHILD_W-1:0] child_type;

   // One request as it travels on req_tdata, last field in the highest bits.
   typedef struct packed {
      coord_type           point_z;
      coord_type           point_y;
      coord_type           point_x;
      child_type           back_child;
      child_type           front_child;
      coord_type           plane_offset;
      coord_type           normal_z;
      coord_type           normal_y;
      coord_type           normal_x;
      logic [INDEX_W-1:0]  node_index;
   } request_word_type;

   // What a locate request must answer.
   typedef struct {
      child_type           region;
      logic [STATUS_W-1:0] status;
   } region_answer_type;

   localparam coord_type COORD_MIN = 32'sh8000_0000;
   localparam coord_type COORD_MAX = 32'sh7fff_ffff;
   localparam coord_type COORD_ONE = 32'sh0001_0000;

   // The plane sum needs 66 bits at most; a little headroom costs nothing.
   localparam int SUM_W = 2 * COORD_W + 4;

   // The tree size register sits at word 0 of the configuration port.
   localparam logic [2:0] TREE_SIZE_ADDR = {CSR_TREE_SIZE, 2'b00};
   localparam int SIZE_ALL_ONES = (1 << SIZE_W) - 1;

   // A node write can still be in flight when the last response has been
   // taken, so let the block settle before touching the register.
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 20;

   // The slowest legal walk visits 1024 nodes; the limit covers far more than
   // the deepest trees this run can build.
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [255:0]        req_tdata = '0;
   logic [0:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // Shadow copy of the node memory and the tree size register, updated in
   // the same order in which the block accepts requests and register writes.
   node_type            node_mem [MAX_NODES];
   logic [SIZE_W-1:0]   tree_size_shadow = '0;

   // Answers still owed by the block, oldest first.
   region_answer_type   expected_regions [$];

   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;

   bsp_point_region_locate_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Walks the shadow tree the way the block must. The plane test is exact:
   // each product is Q32.32, the offset is moved up by the fraction bits to
   // line up with it, and the wide sum is never rounded.
   function automatic region_answer_type locate_region(coord_type px, coord_type py,
                                                       coord_type pz);
      region_answer_type       ans;
      logic signed [SUM_W-1:0] ax, ay, az, nx, ny, nz, off, plane_sum;
      int                      span, node, hops;
      child_type               child;
      bit                      done;
      ans.region = '0;
      ans.status = STATUS_OK;
      ax = px;
      ay = py;
      az = pz;
      span = (int'(tree_size_shadow) > MAX_NODES) ? MAX_NODES : int'(tree_size_shadow);
      node = 0;
      hops = 0;
      done = (span == 0);
      while (!done) begin
         hops++;
         nx = node_mem[node].normal_x;
         ny = node_mem[node].normal_y;
         nz = node_mem[node].normal_z;
         off = node_mem[node].plane_offset;
         plane_sum = ax * nx + ay * ny + az * nz + (off <<< COORD_FRAC_BITS);
         child = (plane_sum > 0) ? node_mem[node].front_child : node_mem[node].back_child;
         if (child <= 0) begin
            ans.region = child;
            done = 1'b1;
         end else if (int'(child) >= span) begin
            ans.status = STATUS_CHILD_OVER;
            done = 1'b1;
         end else if (hops >= MAX_HOPS) begin
            ans.status = STATUS_HOP_LIMIT;
            done = 1'b1;
         end else begin
            node = int'(child);
         end
      end
      return ans;
   endfunction

   // Fields that a request kind does not use are filled with noise, since the
   // block has to ignore them.
   function automatic request_word_type node_word(int idx, coord_type nx, coord_type ny,
                                                  coord_type nz, coord_type off,
                                                  int front, int back);
      request_word_type w;
      w.point_x = $urandom;
      w.point_y = $urandom;
      w.point_z = $urandom;
      w.node_index = INDEX_W'(idx);
      w.normal_x = nx;
      w.normal_y = ny;
      w.normal_z = nz;
      w.plane_offset = off;
      w.front_child = child_type'(front);
      w.back_child = child_type'(back);
      return w;
   endfunction

   function automatic request_word_type point_word(coord_type x, coord_type y, coord_type z);
      request_word_type w;
      w = node_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      w.point_x = x;
      w.point_y = y;
      w.point_z = z;
      return w;
   endfunction

   // A coordinate is sometimes an extreme, sometimes small so that the
   // offset decides the side, and mostly anything at all.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return '0;
               default: return COORD_ONE;
            endcase
         end
         1, 2: return coord_type'(int'($urandom_range(0, 2097152)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   // Children only ever point forward, so random trees have no loops and
   // stay shallow; some point past the tree and many end in a leaf.
   function automatic int pick_child(int idx, int size);
      int span;
      int r;
      span = (size > MAX_NODES) ? MAX_NODES : size;
      r = $urandom_range(0, 99);
      if (r < 60 && idx + 1 < span)
         return $urandom_range(idx + 1, span - 1);
      if (r < 68 && span < MAX_NODES)
         return $urandom_range((span > 0) ? span : 1, MAX_NODES - 1);
      return -int'($urandom_range(0, MAX_NODES));
   endfunction

   function automatic request_word_type make_node(int idx, int size);
      return node_word(idx, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       pick_child(idx, size), pick_child(idx, size));
   endfunction

   // Sends one request and, once the block has taken it, updates the shadow
   // tree or records the answer the block now owes. The valid is only lowered
   // in a cycle the sender chooses to idle, so back to back requests never see
   // a lower and a raise in the same step.
   task automatic send_request(input logic func, input request_word_type word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= func;
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_WRITE_NODE)
         node_mem[word.node_index] = {word.normal_x, word.normal_y, word.normal_z,
                                      word.plane_offset, word.front_child, word.back_child};
      else
         expected_regions.insert(expected_regions.size(),
                                 locate_region(word.point_x, word.point_y, word.point_z));
   endtask

   // Stops sending and waits until every owed response has come back.
   task automatic drain_walks(input int settle);
      req_tvalid <= 1'b0;
      while (expected_regions.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // The register only changes while the block is idle.
   task automatic write_tree_size(input int size);
      drain_walks(SETTLE_CYCLES);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TREE_SIZE_ADDR;
      csr_pwdata <= 32'(size);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      tree_size_shadow = SIZE_W'(size);
   endtask

   // Writes every node the walk can reach for this size, so no walk ever
   // reads a node that was never written.
   task automatic load_tree(input int size);
      int span;
      span = (size > MAX_NODES) ? MAX_NODES : size;
      for (int idx = 0; idx < span; idx++)
         send_request(FUNC_WRITE_NODE, make_node(idx, size));
   endtask

   // Mostly locate requests, with node rewrites that keep the tree loop free
   // and a few writes to slots the current tree does not reach.
   task automatic run_walks(input int count, input int size);
      int span;
      int r;
      span = (size > MAX_NODES) ? MAX_NODES : size;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 80)
            send_request(FUNC_LOCATE, point_word(rand_coord(), rand_coord(), rand_coord()));
         else if (r < 95 || span >= MAX_NODES)
            send_request(FUNC_WRITE_NODE, make_node($urandom_range(0, span - 1), size));
         else
            send_request(FUNC_WRITE_NODE,
                         make_node($urandom_range(span, MAX_NODES - 1), size));
      end
   endtask

   // With no tree loaded every locate answers the void, whatever the point,
   // and a node write alone does not change that.
   task automatic check_empty_tree();
      write_tree_size(0);
      send_request(FUNC_LOCATE, point_word(COORD_MIN, COORD_MIN, COORD_MIN));
      send_request(FUNC_LOCATE, point_word(COORD_MAX, COORD_MAX, COORD_MAX));
      send_request(FUNC_WRITE_NODE, node_word(0, 0, 0, 0, COORD_MAX, 1, -1));
      send_request(FUNC_LOCATE, point_word(0, 0, 0));
   endtask

   // One node tree. A sum of exactly zero goes to the back child, the
   // smallest positive sum goes to the front, the extreme products must not
   // overflow, and the offset must line up with the Q32.32 products.
   task automatic check_plane_sign();
      write_tree_size(1);
      send_request(FUNC_WRITE_NODE, node_word(0, 1, 0, 0, 0, -1024, 0));
      send_request(FUNC_LOCATE, point_word(0, 0, 0));
      send_request(FUNC_LOCATE, point_word(1, 0, 0));
      send_request(FUNC_LOCATE, point_word(-1, 0, 0));
      send_request(FUNC_WRITE_NODE,
                   node_word(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, -1, -2));
      send_request(FUNC_LOCATE, point_word(COORD_MIN, COORD_MIN, COORD_MIN));
      send_request(FUNC_LOCATE, point_word(COORD_MAX, COORD_MAX, COORD_MAX));
      send_request(FUNC_WRITE_NODE, node_word(0, COORD_ONE, 0, 0, -COORD_ONE, -3, -4));
      send_request(FUNC_LOCATE, point_word(COORD_ONE, 0, 0));
      send_request(FUNC_LOCATE, point_word(COORD_ONE + 1, 0, 0));
   endtask

   // Two node tree where every point lies in front. A child equal to the
   // tree size or above stops the walk; a child just below it is followed.
   task automatic check_child_limit();
      write_tree_size(2);
      send_request(FUNC_WRITE_NODE, node_word(0, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 0));
      send_request(FUNC_WRITE_NODE, node_word(1, COORD_MIN, 0, 0, 1, 2, 0));
      send_request(FUNC_LOCATE, point_word(0, 0, 0));
      send_request(FUNC_WRITE_NODE, node_word(1, COORD_MIN, 0, 0, 1, -9, 0));
      send_request(FUNC_LOCATE, point_word(0, 0, 0));
      send_request(FUNC_WRITE_NODE, node_word(0, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1023, 0));
      send_request(FUNC_LOCATE, point_word(0, 0, 0));
   endtask

   // Node 1 points at itself, so the walk only ends at the hop limit.
   task automatic check_hop_limit();
      send_request(FUNC_WRITE_NODE, node_word(0, 0, 0, 0, COORD_MAX, 1, 0));
      send_request(FUNC_WRITE_NODE, node_word(1, 0, 0, 0, COORD_MAX, 1, -3));
      send_request(FUNC_LOCATE, point_word($urandom, $urandom, $urandom));
   endtask

   // Many small random trees; a third of them have only one to three nodes.
   task automatic run_small_trees(input int phases);
      int size;
      for (int p = 0; p < phases; p++) begin
         size = (p % 3 == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
         load_tree(size);
         write_tree_size(size);
         run_walks(36, size);
      end
   endtask

   // Fills the whole node memory, then walks it at full size and with a size
   // register above the memory depth, which must act as full size.
   task automatic run_full_tree();
      load_tree(MAX_NODES);
      write_tree_size(MAX_NODES);
      run_walks(60, MAX_NODES);
      write_tree_size(SIZE_ALL_ONES);
      run_walks(50, SIZE_ALL_ONES);
   endtask

   // The receiver stalls at random in every cycle, following the current
   // idle rate.
   always @(posedge clock)
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);

   // Each response taken is held against the oldest owed answer.
   always @(posedge clock) begin
      region_answer_type want;
      child_type got_region;
      logic [STATUS_W-1:0] got_status;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_region = rsp_tdata[CHILD_W-1:0];
         got_status = rsp_tdata[CHILD_W +: STATUS_W];
         if (expected_regions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: region %0d status %0d",
                        got_region, got_status);
         end else begin
            want = expected_regions.pop_front();
            if (got_region !== want.region || got_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"response mismatch: region expected %0d got %0d, ",
                            "status expected %0d got %0d"},
                           want.region, got_region, want.status, got_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Directed checks first, then random trees under three idle patterns:
   // sender idling less than the receiver, then the other way round, then
   // both sides running flat out.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 72;
      check_empty_tree();
      check_plane_sign();
      check_child_limit();
      check_hop_limit();
      run_small_trees(6);
      send_idle_pct = 72;
      recv_idle_pct = 29;
      run_full_tree();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_small_trees(6);
      drain_walks(TAIL_CYCLES);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
